FILE: rtl/ftcw_pkg.sv
`timescale 1ns / 1ps

package ftcw_pkg;

  localparam int SCREEN_WIDTH   = 80;
  localparam int SCREEN_HEIGHT  = 25;
  localparam int TERMINAL_COUNT = 7;

  localparam int TERM_W   = 3;
  localparam int ADDR_W   = 11;
  localparam int ARG_W    = 32;
  localparam int DIGITS   = 32;
  localparam int DIG_IDX_W = $clog2(DIGITS);
  localparam int DIG_CNT_W = DIG_IDX_W + 1;
  localparam int CFG_W    = 4;

  localparam int COL_W  = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int LINE_W = $clog2(SCREEN_HEIGHT + 1);
  localparam int TIDX_W = (TERMINAL_COUNT > 1) ? $clog2(TERMINAL_COUNT) : 1;

  // x/10 == (x * ceil(2^35/10)) >> 35 for every 32-bit x
  localparam logic [ARG_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int               DIV10_SHIFT = 35;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_PCT   = "%";
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_ALPHA = "a" - 8'd10;
  localparam logic [7:0] CH_D     = "d";
  localparam logic [7:0] CH_O     = "o";
  localparam logic [7:0] CH_X     = "x";
  localparam logic [7:0] CH_B     = "b";

  typedef enum logic [1:0] {
    CFG_ACTIVE_TERMINAL = 2'd0,
    CFG_FG_COLOR        = 2'd1,
    CFG_BG_COLOR        = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX,
    RADIX_BIN
  } radix_e;

  typedef struct packed {
    logic [7:0]              fmt_char;
    logic signed [ARG_W-1:0] arg_value;
  } in_item_t;

  typedef struct packed {
    logic [TERM_W-1:0] terminal;
    logic [ADDR_W-1:0] cell_address;
    logic [7:0]        glyph;
    logic [7:0]        color;
    logic              last;
  } out_item_t;

  // cursor commands from the sequencer
  typedef struct packed {
    logic step;
    logic newline;
  } cur_cmd_t;

  // cursor status at the active terminal
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              visible;
    logic              final_row;  // a step now pushes the cursor below the last line
  } cur_info_t;

  function automatic logic [7:0] digit_ascii(input logic [3:0] d);
    logic [7:0] r;
    if (d > 4'd9) begin
      r = CH_ALPHA + {4'd0, d};
    end else begin
      r = CH_ZERO + {4'd0, d};
    end
    return r;
  endfunction

endpackage

FILE: rtl/formatted_text_console_writer_core.sv
`timescale 1ns / 1ps
// A plain character or %% goes to S_CHAR; its cell leaves the payload registers once the output is free.
// Numeric directives: one digit per cycle for radix 2/8/16; radix 10 adds a multiply step per digit
// (shared reciprocal-multiply divider), then an optional sign cell and one cell per digit.
// A %b of a 32-bit value gives up to 32 digits; input is stalled until the item is done.
// Newline, percent and end-of-string items are taken in S_IDLE and give no cell.
// Reset (async, active low): cursors at 0, no pending percent, terminal 0, colors 7/0.
module formatted_text_console_writer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ftcw_pkg::in_item_t         in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ftcw_pkg::out_item_t        out_item_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [ftcw_pkg::CFG_W-1:0] cfg_wdata_i
);
  import ftcw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,   // digits come out of the divider, least significant first
    S_SIGN,  // optional minus; also lets the digit store read settle
    S_DIGS,  // digits go out most significant first
    S_CHAR   // single cell: plain char, %% or unknown directive
  } state_e;

  state_e             state_q, state_d;
  logic               pend_q, pend_d;
  logic [7:0]         char_q, char_d;
  logic               neg_q, neg_d;
  radix_e             radix_q, radix_d;
  logic [DIG_CNT_W-1:0] k_q, k_d;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [TERM_W-1:0]  term_q;
  logic [3:0]         fg_q;
  logic [3:0]         bg_q;

  // digit store: written during S_DIV, read back in reverse
  logic [3:0]           digit_mem [DIGITS];
  logic [3:0]           rd_q;
  logic [DIG_CNT_W-1:0] rd_cnt;

  logic               in_acc;
  logic [7:0]         ch;
  logic [ARG_W-1:0]   arg;
  logic [ARG_W-1:0]   abs_arg;

  logic               div_start;
  logic [ARG_W-1:0]   div_mag;
  logic               div_done;
  logic [ARG_W-1:0]   div_quot;
  logic [3:0]         div_rem;

  cur_cmd_t           cur_cmd;
  cur_info_t          cur;

  logic               out_free;
  logic               emit_req;
  logic               emit_go;
  logic [7:0]         glyph;
  logic               last;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ch         = in_item_i.fmt_char;
  assign arg        = in_item_i.arg_value;
  // the most negative value maps to unsigned 2^31
  assign abs_arg    = arg[ARG_W-1] ? (ARG_W'(0) - arg) : arg;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit_req = (state_q == S_CHAR) || (state_q == S_DIGS) ||
                    (state_q == S_SIGN && neg_q);
  // cells below the last line are dropped, so they never wait on the output
  assign emit_go  = emit_req && (!cur.visible || out_free);

  always_comb begin
    unique case (state_q)
      S_SIGN: begin
        glyph = CH_MINUS;
        last  = cur.final_row;
      end
      S_DIGS: begin
        glyph = digit_ascii(rd_q);
        last  = (k_q == DIG_CNT_W'(1)) || cur.final_row;
      end
      default: begin
        glyph = char_q;
        last  = 1'b1;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    pend_d    = pend_q;
    char_d    = char_q;
    neg_d     = neg_q;
    radix_d   = radix_q;
    k_d       = k_q;
    div_start = 1'b0;
    div_mag   = div_quot;
    cur_cmd   = '0;
    unique case (state_q)
      S_IDLE: begin
        div_mag = abs_arg;
        if (in_acc) begin
          priority if (ch == CH_NUL) begin
            pend_d = 1'b0;
          end else if (pend_q) begin
            pend_d  = 1'b0;
            neg_d   = arg[ARG_W-1];
            k_d     = '0;
            state_d = S_DIV;
            unique case (ch)
              CH_D: radix_d = RADIX_DEC;
              CH_O: radix_d = RADIX_OCT;
              CH_X: radix_d = RADIX_HEX;
              CH_B: radix_d = RADIX_BIN;
              default: begin
                state_d = S_CHAR;
                char_d  = (ch == CH_PCT) ? CH_PCT : CH_HASH;
              end
            endcase
            div_start = (state_d == S_DIV);
          end else if (ch == CH_PCT) begin
            pend_d = 1'b1;
          end else if (ch == CH_NL) begin
            cur_cmd.newline = 1'b1;
          end else begin
            char_d  = ch;
            state_d = S_CHAR;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          k_d = k_q + 1'b1;
          if (div_quot != '0 && k_q != DIG_CNT_W'(DIGITS - 1)) begin
            div_start = 1'b1;
          end else begin
            state_d = S_SIGN;
          end
        end
      end
      S_SIGN: begin
        if (!neg_q) begin
          state_d = S_DIGS;
        end else if (emit_go) begin
          cur_cmd.step = 1'b1;
          state_d      = S_DIGS;
        end
      end
      S_DIGS: begin
        if (emit_go) begin
          cur_cmd.step = 1'b1;
          k_d          = k_q - 1'b1;
          if (k_q == DIG_CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_CHAR: begin
        if (emit_go) begin
          cur_cmd.step = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      term_q      <= '0;
      fg_q        <= 4'd7;
      bg_q        <= 4'd0;
      k_q         <= '0;
      neg_q       <= 1'b0;
      radix_q     <= RADIX_DEC;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      k_q     <= k_d;
      neg_q   <= neg_d;
      radix_q <= radix_d;
      if (emit_go && cur.visible) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ACTIVE_TERMINAL: begin
            if (cfg_wdata_i[TERM_W-1:0] < TERM_W'(TERMINAL_COUNT)) begin
              term_q <= cfg_wdata_i[TERM_W-1:0];
            end
          end
          CFG_FG_COLOR: fg_q <= cfg_wdata_i;
          CFG_BG_COLOR: bg_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    if (emit_go && cur.visible) begin
      out_q.terminal     <= term_q;
      out_q.cell_address <= cur.addr;
      out_q.glyph        <= glyph;
      out_q.color        <= {bg_q, fg_q};
      out_q.last         <= last;
    end
  end

  // read address tracks the next count so rd_q holds entry k-1 in S_DIGS
  assign rd_cnt = k_d - 1'b1;

  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV && div_done) begin
      digit_mem[k_q[DIG_IDX_W-1:0]] <= div_rem;
    end
    rd_q <= digit_mem[rd_cnt[DIG_IDX_W-1:0]];
  end

  ftcw_div_unit u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (div_mag),
    .radix_i (radix_d),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  ftcw_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .term_i (term_q),
    .cmd_i  (cur_cmd),
    .info_o (cur)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // divider results only arrive while digits are being collected
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider result outside digit collection");

  // digit count never exceeds the store depth
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= DIG_CNT_W'(DIGITS))
    else $error("digit count out of range");

  // a visible single-cell item shows up next cycle flagged as last
  a_char_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHAR && emit_go && cur.visible) |=> (out_valid_o && out_item_o.last))
    else $error("single cell not delivered as last");

  // digit emission only starts after at least one digit is stored
  a_digs_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIGS |-> k_q != '0)
    else $error("digit emission with empty store");

endmodule

FILE: rtl/ftcw_div_unit.sv
`timescale 1ns / 1ps

// One digit per request: quotient and remainder of mag_i by the radix.
// Power-of-two radix: shift and mask. Radix 10: reciprocal multiply, then U_MUL forms quotient and remainder.
module ftcw_div_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ftcw_pkg::ARG_W-1:0] mag_i,
  input  ftcw_pkg::radix_e         radix_i,
  output logic                     done_o,
  output logic [ftcw_pkg::ARG_W-1:0] quot_o,
  output logic [3:0]               rem_o
);
  import ftcw_pkg::*;

  typedef enum logic {
    U_IDLE,
    U_MUL
  } ustate_e;

  ustate_e              state_q;
  logic                 done_q;
  logic [2*ARG_W-1:0]   prod_q;
  logic [ARG_W-1:0]     mag_q;
  logic [ARG_W-1:0]     quot_q;
  logic [3:0]           rem_q;
  logic [ARG_W-1:0]     q10;
  logic [ARG_W-1:0]     q10_times;
  logic [ARG_W-1:0]     r10;

  assign q10       = ARG_W'(prod_q >> DIV10_SHIFT);
  assign q10_times = (q10 << 3) + (q10 << 1);
  assign r10       = mag_q - q10_times;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        U_IDLE: begin
          if (start_i) begin
            unique case (radix_i)
              RADIX_DEC: begin
                state_q <= U_MUL;
              end
              RADIX_OCT: begin
                done_q <= 1'b1;
              end
              RADIX_HEX: begin
                done_q <= 1'b1;
              end
              RADIX_BIN: begin
                done_q <= 1'b1;
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        U_MUL: begin
          done_q  <= 1'b1;
          state_q <= U_IDLE;
        end
        default: begin
          state_q <= U_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == U_IDLE && start_i) begin
      mag_q  <= mag_i;
      prod_q <= mag_i * DIV10_RECIP;
      unique case (radix_i)
        RADIX_OCT: begin
          quot_q <= mag_i >> 3;
          rem_q  <= {1'b0, mag_i[2:0]};
        end
        RADIX_HEX: begin
          quot_q <= mag_i >> 4;
          rem_q  <= mag_i[3:0];
        end
        RADIX_BIN: begin
          quot_q <= mag_i >> 1;
          rem_q  <= {3'd0, mag_i[0]};
        end
        default: begin
          quot_q <= quot_q;
          rem_q  <= rem_q;
        end
      endcase
    end else if (state_q == U_MUL) begin
      quot_q <= q10;
      rem_q  <= r10[3:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/ftcw_cursor.sv
`timescale 1ns / 1ps

// Per-terminal cursor store with cell address and wrap logic.
module ftcw_cursor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ftcw_pkg::TERM_W-1:0] term_i,
  input  ftcw_pkg::cur_cmd_t          cmd_i,
  output ftcw_pkg::cur_info_t         info_o
);
  import ftcw_pkg::*;

  localparam int PROD_W = LINE_W + COL_W + 8;

  logic [LINE_W-1:0] line_q [TERMINAL_COUNT];
  logic [COL_W-1:0]  col_q  [TERMINAL_COUNT];

  logic [TIDX_W-1:0] idx;
  logic [LINE_W-1:0] line;
  logic [COL_W-1:0]  col;
  logic [COL_W:0]    col_inc;
  logic              wrap;
  logic              visible;
  logic [PROD_W-1:0] addr_full;

  assign idx     = TIDX_W'(term_i);
  assign line    = line_q[idx];
  assign col     = col_q[idx];
  assign col_inc = {1'b0, col} + 1'b1;
  assign wrap    = col_inc >= (COL_W + 1)'(SCREEN_WIDTH);
  assign visible = line < LINE_W'(SCREEN_HEIGHT);

  assign addr_full = PROD_W'(line) * PROD_W'(SCREEN_WIDTH) + PROD_W'(col);

  assign info_o.addr      = addr_full[ADDR_W-1:0];
  assign info_o.visible   = visible;
  assign info_o.final_row = visible && wrap &&
                            ((line + 1'b1) == LINE_W'(SCREEN_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TERMINAL_COUNT; i++) begin
        line_q[i] <= '0;
        col_q[i]  <= '0;
      end
    end else if (cmd_i.newline) begin
      col_q[idx] <= '0;
      if (visible) begin
        line_q[idx] <= line + 1'b1;
      end
    end else if (cmd_i.step) begin
      col_q[idx] <= wrap ? '0 : col_inc[COL_W-1:0];
      if (wrap && visible) begin
        line_q[idx] <= line + 1'b1;
      end
    end
  end

endmodule
